// ===== src/tws_pkg.sv =====
`timescale 1ns / 1ps
package tws_pkg;

  localparam int MaxStates    = 4;
  localparam int NumStatesDef = 4;
  localparam int DataW        = 32;
  localparam int EpsW         = 16;
  localparam int CntW         = 3;
  localparam int RowW         = 2;
  localparam int AddrW        = 3;

  localparam logic RegEps = 1'b0;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    word_t [MaxStates-1:0]                rem;
    word_t [MaxStates-1:0][MaxStates-1:0] flow;
  } mat_t;

  typedef struct packed {
    mat_t            m;
    logic            active;
    word_t           v1;
    word_t           v2;
    word_t           v3;
    logic [CntW-1:0] n1;
    logic [CntW-1:0] n2;
  } rnd_t;

  function automatic word_t div3(input word_t x);
    logic [2*DataW-1:0] p;
    p = {{DataW{1'b0}}, x} * {{DataW{1'b0}}, 32'hAAAA_AAAB};
    return {1'b0, p[2*DataW-1:DataW+1]};
  endfunction

endpackage

// ===== src/tws_sort.sv =====
`timescale 1ns / 1ps
module tws_sort #(
  parameter int N = tws_pkg::NumStatesDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          vld_i,
  input  tws_pkg::word_t [tws_pkg::MaxStates-1:0]        weight_i,
  output logic                                          vld_o,
  output tws_pkg::mat_t                                 mat_o
);
  import tws_pkg::*;

  logic  vld_q;
  mat_t  mat_q, mat_d;
  word_t [MaxStates-1:0] w;
  word_t t;

  always_comb begin
    w = weight_i;
    t = '0;
    for (int ps = 0; ps < N - 1; ps++) begin
      for (int j = 0; j < N - 1 - ps; j++) begin
        if (w[j] > w[j+1]) begin
          t      = w[j];
          w[j]   = w[j+1];
          w[j+1] = t;
        end
      end
    end
    mat_d = '0;
    for (int i = 0; i < N; i++) begin
      mat_d.rem[i] = w[N-1-i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q <= mat_d;
    end
  end

  assign vld_o = vld_q;
  assign mat_o = mat_q;

endmodule

// ===== src/tws_round.sv =====
`timescale 1ns / 1ps
module tws_round #(
  parameter int N = tws_pkg::NumStatesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [tws_pkg::EpsW-1:0]     eps_i,
  input  logic                         vld_i,
  input  tws_pkg::mat_t                mat_i,
  output logic                         vld_o,
  output tws_pkg::mat_t                mat_o
);
  import tws_pkg::*;

  rnd_t a_d, a_q;
  logic a_vld_q, b_vld_q;
  mat_t b_d, b_q;

  logic            f1, seen2, done2;
  word_t           x, dd, d2, new1, new2, diff, d1, d2n;
  logic [DataW+1:0] y;

  always_comb begin
    a_d        = '0;
    a_d.m      = mat_i;
    a_d.active = mat_i.rem[1] > {{(DataW-EpsW){1'b0}}, eps_i};
    a_d.v1     = mat_i.rem[0];
    a_d.n1     = CntW'(N);
    f1         = 1'b0;
    for (int p = 1; p < N; p++) begin
      if (!f1 && mat_i.rem[p] != mat_i.rem[0]) begin
        a_d.n1 = CntW'(p);
        f1     = 1'b1;
      end
    end
    seen2 = 1'b0;
    done2 = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (CntW'(k) >= a_d.n1 && !done2) begin
        if (!seen2) begin
          a_d.v2 = mat_i.rem[k];
          a_d.n2 = CntW'(1);
          seen2  = 1'b1;
        end else if (mat_i.rem[k] == a_d.v2) begin
          a_d.n2 = a_d.n2 + CntW'(1);
        end else begin
          a_d.v3 = mat_i.rem[k];
          done2  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    b_d  = a_q.m;
    x    = a_q.v1 - a_q.v2;
    dd   = a_q.v2 - a_q.v3;
    diff = x;
    y    = '0;
    d2   = '0;
    new1 = '0;
    new2 = '0;
    d2n  = '0;
    d1   = '0;
    if (a_q.n2 == CntW'(2)) begin
      y = {2'b00, dd};
    end else if (a_q.n2 == CntW'(3)) begin
      y = {1'b0, dd, 1'b0};
    end
    if (a_q.active) begin
      if (a_q.n1 == CntW'(1)) begin
        if ({2'b00, x} < y) begin
          d2   = (a_q.n2 == CntW'(3)) ? (x >> 1) : x;
          new2 = a_q.v2 - d2;
          new1 = new2;
        end else begin
          d2 = dd;
          if (a_q.n2 == CntW'(3)) begin
            d2n = (d2 << 1) + d2;
          end else if (a_q.n2 == CntW'(2)) begin
            d2n = d2 << 1;
          end else begin
            d2n = d2;
          end
          new2 = a_q.v3;
          new1 = a_q.v1 - d2n;
        end
        b_d.rem[0] = new1;
        for (int k = 1; k < N; k++) begin
          if (CntW'(k) <= a_q.n2) begin
            b_d.flow[N-1][N-1-k] = b_d.flow[N-1][N-1-k] + d2;
            b_d.flow[N-1-k][N-1] = b_d.flow[N-1-k][N-1] + d2;
            b_d.rem[k]           = new2;
          end
        end
      end else begin
        if (a_q.n1 == CntW'(2)) begin
          d1 = diff;
        end else if (a_q.n1 == CntW'(3)) begin
          d1 = diff >> 1;
        end else begin
          d1 = div3(diff);
        end
        for (int i = 0; i < N; i++) begin
          if (CntW'(i) < a_q.n1) begin
            b_d.rem[i] = a_q.v2;
            for (int j = 0; j < N; j++) begin
              if (CntW'(j) < a_q.n1 && i != j) begin
                b_d.flow[N-1-i][N-1-j] = b_d.flow[N-1-i][N-1-j] + d1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign vld_o = b_vld_q;
  assign mat_o = b_q;

endmodule

// ===== src/tws_out.sv =====
`timescale 1ns / 1ps
module tws_out #(
  parameter int N = tws_pkg::NumStatesDef
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     vld_i,
  input  tws_pkg::mat_t                            mat_i,
  output logic                                     adv_o,
  output logic                                     tvalid_o,
  input  logic                                     tready_i,
  output logic [tws_pkg::RowW-1:0]                 row_o,
  output tws_pkg::word_t [tws_pkg::MaxStates-1:0]  flow_o,
  output logic                                     last_o
);
  import tws_pkg::*;

  logic            busy_q;
  logic [RowW-1:0] row_q;
  mat_t            mat_q, mat_d;
  logic            last, fin, load;

  assign last  = row_q == RowW'(N - 1);
  assign fin   = busy_q && tready_i && last;
  assign load  = vld_i && (!busy_q || fin);
  assign adv_o = !vld_i || load;

  always_comb begin
    mat_d = mat_i;
    mat_d.flow[N-1][N-1] = mat_i.flow[N-1][N-1] + mat_i.rem[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (busy_q && tready_i) begin
      row_q <= row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= mat_d;
    end
  end

  always_comb begin
    for (int j = 0; j < MaxStates; j++) begin
      flow_o[j] = (j < N) ? mat_q.flow[row_q][j] : '0;
    end
  end

  assign tvalid_o = busy_q;
  assign row_o    = row_q;
  assign last_o   = last;

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tvalid_o && last_o |-> row_o == RowW'(N - 1)) else $error("last flag off final row");
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tvalid_o && tready_i && !last_o |=> tvalid_o && row_o == $past(row_o) + RowW'(1))
    else $error("row skipped or repeated");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i && busy_q && !fin |-> !adv_o) else $error("pipeline advanced over full output");

endmodule

// ===== src/transition_weight_solver_unit.sv =====
`timescale 1ns / 1ps
// Throughput is set by the row serializer, which drives one matrix row per cycle
// while m_axis_tready is high; the pipeline holds while a finished matrix waits
// for the serializer. The lowering rounds run in a 2*(NUM_STATES+1)-stage pipeline
// behind a sort stage.
// Reset: rst_ni async active low clears all valid bits and eps to 0.
module transition_weight_solver_unit #(
  parameter int NUM_STATES = tws_pkg::NumStatesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tws_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // weight0, weight1, weight2, weight3
  input  logic [127:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // row[1:0], flow_to0, flow_to1, flow_to2, flow_to3, zero pad
  output logic [135:0]                  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import tws_pkg::*;

  localparam int NumRounds = NUM_STATES + 1;

  logic [EpsW-1:0]       eps_q;
  logic                  adv;
  word_t [MaxStates-1:0] win;
  logic [NumRounds:0]    vld;
  mat_t  [NumRounds:0]   mat;
  logic [RowW-1:0]       row;
  word_t [MaxStates-1:0] flow;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == RegEps) begin
      eps_q <= pwdata[EpsW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegEps) ? {{(32-EpsW){1'b0}}, eps_q} : '0;

  always_comb begin
    for (int i = 0; i < MaxStates; i++) begin
      win[i] = s_axis_tdata[i*DataW +: DataW];
    end
  end

  assign s_axis_tready = adv;

  tws_sort #(.N(NUM_STATES)) u_sort (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (s_axis_tvalid),
    .weight_i (win),
    .vld_o    (vld[0]),
    .mat_o    (mat[0])
  );

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    tws_round #(.N(NUM_STATES)) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .eps_i  (eps_q),
      .vld_i  (vld[r]),
      .mat_i  (mat[r]),
      .vld_o  (vld[r+1]),
      .mat_o  (mat[r+1])
    );
  end

  tws_out #(.N(NUM_STATES)) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld[NumRounds]),
    .mat_i    (mat[NumRounds]),
    .adv_o    (adv),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .row_o    (row),
    .flow_o   (flow),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, flow[3], flow[2], flow[1], flow[0], row};

endmodule

// ===== tb/tb_transition_weight_solver_unit.sv =====
`timescale 1ns / 1ps
module tb_transition_weight_solver_unit;
  import tws_pkg::*;

  localparam int NS = NumStatesDef;
  localparam int RowCycles = 2 * NS + 12;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] flow [4];
    logic        last;
  } row_rec_t;

  class matrix_board;
    row_rec_t rows_q[$];
    int unsigned errors;
    logic [15:0] eps;

    function void note_request(logic [31:0] win [4]);
      logic [63:0] w [4];
      logic [63:0] rem [4];
      logic [63:0] flow [4][4];
      logic [63:0] v1, v2, v3, x, y, d1, d2, new1, new2, t;
      int n1, n2, p, q, i, j, k;
      row_rec_t r;
      for (i = 0; i < NS; i++) w[i] = {32'd0, win[i]};
      for (i = 1; i < NS; i++) begin
        t = w[i];
        j = i;
        while (j > 0 && w[j-1] > t) begin
          w[j] = w[j-1];
          j--;
        end
        w[j] = t;
      end
      for (i = 0; i < NS; i++) rem[i] = w[NS-1-i];
      for (i = 0; i < 4; i++) for (j = 0; j < 4; j++) flow[i][j] = 0;
      for (int rnd = 0; rnd <= NS; rnd++) begin
        if (rem[1] <= {48'd0, eps}) break;
        v1 = rem[0];
        for (p = 0; p < NS; p++) if (rem[p] != v1) break;
        n1 = p;
        if (p == NS) begin
          v2 = 0; v3 = 0; n2 = 0;
        end else begin
          v2 = rem[p];
          for (q = p; q < NS; q++) if (rem[q] != v2) break;
          v3 = (q == NS) ? 0 : rem[q];
          n2 = q - p;
        end
        if (n1 == 1) begin
          x = v1 - v2;
          y = (n2 - 1) * (v2 - v3);
          if (x < y) begin
            d2 = x / (n2 - 1);
            new2 = v2 - d2;
            new1 = new2;
          end else begin
            d2 = v2 - v3;
            new2 = v3;
            new1 = v1 - d2 * n2;
          end
          rem[0] = new1;
          for (k = 1; k <= n2 && k < NS; k++) begin
            flow[NS-1][NS-1-k] += d2;
            flow[NS-1-k][NS-1] += d2;
            rem[k] = new2;
          end
        end else begin
          d1 = (v1 - v2) / (n1 - 1);
          for (i = 0; i < n1; i++) begin
            rem[i] = v2;
            for (j = 0; j < n1; j++) if (i != j) flow[NS-1-i][NS-1-j] += d1;
          end
        end
      end
      if (rem[0] > 0) flow[NS-1][NS-1] += rem[0];
      for (i = 0; i < NS; i++) begin
        r.row = i[1:0];
        for (j = 0; j < 4; j++) r.flow[j] = (j < NS) ? flow[i][j][31:0] : 32'd0;
        r.last = (i == NS - 1);
        rows_q.push_back(r);
      end
    endfunction

    function void check_row(logic [135:0] d, logic last);
      row_rec_t e;
      if (rows_q.size() == 0) begin
        $display("%0t: unexpected row, actual %h last %b", $time, d, last);
        errors++;
        return;
      end
      e = rows_q.pop_front();
      if (d[1:0] !== e.row) begin
        $display("%0t: row idx expected %0d actual %0d", $time, e.row, d[1:0]);
        errors++;
      end
      for (int j = 0; j < 4; j++)
        if (d[2+32*j +: 32] !== e.flow[j]) begin
          $display("%0t: row %0d flow_to%0d expected %h actual %h", $time, e.row, j,
                   e.flow[j], d[2+32*j +: 32]);
          errors++;
        end
      if (d[135:130] !== 6'd0) begin
        $display("%0t: pad expected 0 actual %h", $time, d[135:130]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: tlast expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [127:0] s_axis_tdata;
  logic [135:0] m_axis_tdata;

  matrix_board board;
  int unsigned cycles;
  bit calm;
  logic [31:0] wv [4];

  transition_weight_solver_unit #(.NUM_STATES(NS)) dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    board.eps = 0;
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
    calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
  initial cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_row(m_axis_tdata, m_axis_tlast);
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(99) >= 32);
  end

  task automatic write_eps(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AddrW'(4 * RegEps); pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.eps = v;
  endtask

  task automatic send_weights(logic [31:0] a [4], bit sorted);
    logic [31:0] b [4];
    logic [31:0] t;
    b = a;
    if (sorted)
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3 - i; j++)
          if (b[j] > b[j+1]) begin
            t = b[j]; b[j] = b[j+1]; b[j+1] = t;
          end
    while (!calm && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {b[3], b[2], b[1], b[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(b);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.rows_q.size() != 0) @(posedge clk_i);
    repeat (RowCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_weight(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(8) << 16;
      2: return $urandom_range(5);
      default: return {16'd0, 16'($urandom())} + (32'($urandom_range(3)) << 16);
    endcase
  endfunction

  initial begin
    wait (rst_ni);
    write_eps(16'd0);
    wv = '{0, 0, 0, 0};                                   send_weights(wv, 0);
    wv = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; send_weights(wv, 0);
    wv = '{0, 0, 0, 32'hFFFF_FFFF};                       send_weights(wv, 0);
    wv = '{32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000}; send_weights(wv, 0);
    wv = '{32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h5_0000}; send_weights(wv, 0);
    wv = '{32'h1_0000, 32'h3_0000, 32'h3_0000, 32'h3_0001}; send_weights(wv, 0);
    wv = '{0, 32'h2_0000, 32'h2_0000, 32'h2_0000};        send_weights(wv, 0);
    wv = '{32'h4_0000, 32'h3_0000, 32'h2_0000, 32'h1_0000}; send_weights(wv, 0);
    wv = '{32'h9, 32'h1, 32'h9, 32'h1};                   send_weights(wv, 0);
    wv = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}; send_weights(wv, 0);
    wv = '{1, 2, 3, 3};                                   send_weights(wv, 0);
    wv = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF}; send_weights(wv, 0);
    drain();
    write_eps(16'hFFFF);
    wv = '{32'h0_8000, 32'h0_FFFF, 32'h1_0000, 32'h2_0000}; send_weights(wv, 0);
    wv = '{0, 32'hFFFF, 32'hFFFF, 32'h3_0000};            send_weights(wv, 0);
    drain();
    calm = 1;
    for (int ph = 0; ph < 4; ph++) begin
      write_eps(ph == 0 ? 16'd0 : ph == 1 ? 16'($urandom()) : ph == 2 ? 16'hFFFF : 16'd1);
      for (int n = 0; n < 64; n++) begin
        for (int i = 0; i < 4; i++) wv[i] = rand_weight($urandom_range(3));
        if ($urandom_range(3) == 0) wv[$urandom_range(3)] = wv[$urandom_range(3)];
        send_weights(wv, $urandom_range(9) != 0);
        if (n == 30) drain();
      end
      calm = 0;
      drain();
    end
    $display("Covered directed extremes, ties and unsorted weights, plus 256 random requests");
    $display("over four eps settings with random stalls on both streams.");
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== transition_weight_solver_unit.f =====
src/tws_pkg.sv
src/tws_sort.sv
src/tws_round.sv
src/tws_out.sv
src/transition_weight_solver_unit.sv
tb/tb_transition_weight_solver_unit.sv
